// File: sv/ecagen_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecagen_pkg
// Shared sizes, register map, state codes and the rule lookup for the
// elementary cellular automaton generator.
// ----------------------------------------------------------------------------
package ecagen_pkg;

   // row geometry and history depth
   localparam int CELLS        = 32;
   localparam int HISTORY_ROWS = 32;

   localparam int COL_W  = $clog2(CELLS);
   localparam int ROW_W  = $clog2(HISTORY_ROWS);
   localparam int LIVE_W = $clog2(CELLS + 1);

   typedef logic [CELLS-1:0]        row_type;
   typedef logic [HISTORY_ROWS-1:0] hist_mask_type;

   // output field widths
   localparam int COUNT_FIELD_W = 6;
   localparam int COORD_FIELD_W = 5;

   // single center cell used when a reseed gives an empty row
   localparam row_type CENTER_ROW = row_type'(1) << (CELLS / 2);

   // generator constants
   localparam logic [31:0] SEED_MULT   = 32'd2654435761;
   localparam logic [31:0] SEED_ADD    = 32'd1;
   localparam logic [31:0] LCG_MULT    = 32'd1664525;
   localparam logic [31:0] LCG_ADD     = 32'd1013904223;
   localparam logic [7:0]  CELL_THRESH = 8'd70;
   localparam logic [16:0] SEED_MAX    = 17'd99999;

   // register map (byte addresses)
   localparam int          CSR_ADDR_W     = 4;
   localparam logic [3:0]  ADDR_RULE      = 4'h0;
   localparam logic [3:0]  ADDR_STEP      = 4'h4;
   localparam logic [3:0]  ADDR_SEED      = 4'h8;
   localparam logic [7:0]  RULE_RESET     = 8'd30;
   localparam logic [31:0] STEP_RESET     = 32'd357913;
   localparam logic [16:0] SEED_RESET     = 17'd0;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SEED  = 3'd1;
   localparam logic [2:0] ST_LCG   = 3'd2;
   localparam logic [2:0] ST_FIX   = 3'd3;
   localparam logic [2:0] ST_PHASE = 3'd4;
   localparam logic [2:0] ST_COUNT = 3'd5;
   localparam logic [2:0] ST_SCAN  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   // one circular generation: every cell looks up its neighbourhood in the rule
   function automatic row_type ca_evolve(input row_type row, input logic [7:0] rule);
      row_type    next;
      logic [2:0] hood;
      next = '0;
      for (int i = 0; i < CELLS; i++) begin
         hood    = {row[(i + CELLS - 1) % CELLS], row[i], row[(i + 1) % CELLS]};
         next[i] = rule[hood];
      end
      return next;
   endfunction

endpackage

// File: sv/elementary_ca_generator_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementary_ca_generator_scan
// Elementary cellular automaton row with a history ring and a spacetime scan.
// ----------------------------------------------------------------------------
// One request carries a reset level sample and gives one response with the
// live and changed cell counts and one scanned history cell. The block works
// on one request at a time and drops req_tready while busy. After it is
// accepted, a plain request passes the phase add, history read and output
// states. A request that triggers a generation also passes the bit-serial
// live/changed count. A rising edge of reset_level first reseeds: the
// seed generator runs one multiply-add per cycle on a single shared 32-bit
// multiplier, one row cell per step. After reset the block reseeds itself
// from seed 0 before it raises req_tready; register writes are taken at
// any time. A finished response waits in the output register while the
// next request is already being accepted and worked on.
// ----------------------------------------------------------------------------
module elementary_ca_generator_scan
   import ecagen_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] reset_level
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [5:0] live_count, [11:6] changed_count,
                                              // [12] scan_alive, [17:13] scan_column,
                                              // [22:18] scan_row
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [7:0]  rule_ff;
   logic [31:0] step_ff;
   logic [16:0] seed_ff;
   logic        csr_wr;

   // sequencer and datapath state
   logic [2:0]          state_ff, state_in;
   logic                init_ff, init_in;
   logic                seen_ff, seen_in;
   logic [31:0]         rng_ff, rng_in;
   logic [16:0]         seed_use_ff, seed_use_in;
   logic [COL_W-1:0]    cnt_ff, cnt_in;
   row_type             row_ff, row_in;
   row_type             cnt_row_ff, cnt_row_in;
   row_type             cnt_diff_ff, cnt_diff_in;
   logic [LIVE_W-1:0]   live_ff, live_in;
   logic [LIVE_W-1:0]   changed_ff, changed_in;
   logic [31:0]         phase_ff, phase_in;
   logic [ROW_W-1:0]    newest_ff, newest_in;
   hist_mask_type       valid_ff, valid_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    srow_ff, srow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_data_ff, rsp_data_in;

   // history memory, one write and one registered read port
   row_type             ring_mem [HISTORY_ROWS];
   row_type             rd_row_ff;
   logic                rd_valid_ff;
   logic                mem_we;
   logic [ROW_W-1:0]    mem_waddr;
   row_type             mem_wdata;
   logic                mem_re;
   logic [ROW_W-1:0]    mem_raddr;

   // shared multiply-add unit for the seed generator
   logic [31:0] mul_a, mul_b, mul_c, mul_out;
   logic        cell_bit;

   // misc combinational helpers
   logic [32:0]      phase_sum;
   row_type          next_row;
   logic [ROW_W-1:0] newest_adv;
   logic [ROW_W:0]   ring_sum;
   logic [ROW_W-1:0] ring_idx;
   logic             accept;

   // ---------------------------------------------------------------- registers port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff <= RULE_RESET;
         step_ff <= STEP_RESET;
         seed_ff <= SEED_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr)
            ADDR_RULE: rule_ff <= csr_pwdata[7:0];
            ADDR_STEP: step_ff <= csr_pwdata;
            ADDR_SEED: seed_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_RULE: csr_prdata = {24'd0, rule_ff};
         ADDR_STEP: csr_prdata = step_ff;
         ADDR_SEED: csr_prdata = {15'd0, seed_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- shared unit
   // first pass hashes the seed, the following passes are the lcg steps
   always_comb begin
      if (state_ff == ST_SEED) begin
         mul_a = {15'd0, seed_use_ff};
         mul_b = SEED_MULT;
         mul_c = SEED_ADD;
      end else begin
         mul_a = rng_ff;
         mul_b = LCG_MULT;
         mul_c = LCG_ADD;
      end
      mul_out  = mul_a * mul_b + mul_c;
      cell_bit = (mul_out[7:0] < CELL_THRESH);
   end

   // ---------------------------------------------------------------- helpers
   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign phase_sum  = {1'b0, phase_ff} + {1'b0, step_ff};
   assign next_row   = ca_evolve(row_ff, rule_ff);
   assign newest_adv = (newest_ff == ROW_W'(HISTORY_ROWS - 1)) ? '0 : newest_ff + 1'b1;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      seen_in      = seen_ff;
      rng_in       = rng_ff;
      seed_use_in  = seed_use_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      cnt_row_in   = cnt_row_ff;
      cnt_diff_in  = cnt_diff_ff;
      live_in      = live_ff;
      changed_in   = changed_ff;
      phase_in     = phase_ff;
      newest_in    = newest_ff;
      valid_in     = valid_ff;
      col_in       = col_ff;
      srow_in      = srow_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = newest_adv;
      mem_wdata    = next_row;
      mem_re       = 1'b0;
      ring_sum     = '0;
      ring_idx     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seen_in = req_tdata[0];
               // rising edge of the level reseeds before the phase step
               if (req_tdata[0] && !seen_ff) begin
                  seed_use_in = (seed_ff > SEED_MAX) ? SEED_MAX : seed_ff;
                  state_in    = ST_SEED;
               end else begin
                  state_in = ST_PHASE;
               end
            end
         end

         ST_SEED: begin
            rng_in   = mul_out;
            row_in   = '0;
            live_in  = '0;
            cnt_in   = '0;
            state_in = ST_LCG;
         end

         ST_LCG: begin
            // cells fill from the top and shift down, first step lands in cell 0
            rng_in  = mul_out;
            row_in  = {cell_bit, row_ff[CELLS-1:1]};
            live_in = live_ff + LIVE_W'(cell_bit);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == COL_W'(CELLS - 1)) begin
               state_in = ST_FIX;
            end
         end

         ST_FIX: begin
            // empty row falls back to one center cell
            if (row_ff == '0) begin
               row_in  = CENTER_ROW;
               live_in = LIVE_W'(1);
            end
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = (row_ff == '0) ? CENTER_ROW : row_ff;
            valid_in   = hist_mask_type'(1);
            newest_in  = '0;
            phase_in   = '0;
            changed_in = '0;
            init_in    = 1'b0;
            state_in   = init_ff ? ST_IDLE : ST_PHASE;
         end

         ST_PHASE: begin
            phase_in = phase_sum[31:0];
            if (phase_sum[32]) begin
               // carry out: one generation into the next ring slot
               row_in              = next_row;
               cnt_row_in          = next_row;
               cnt_diff_in         = next_row ^ row_ff;
               newest_in           = newest_adv;
               mem_we              = 1'b1;
               valid_in[newest_adv] = 1'b1;
               live_in             = '0;
               changed_in          = '0;
               cnt_in              = '0;
               state_in            = ST_COUNT;
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_COUNT: begin
            // one row bit into each count per cycle
            live_in     = live_ff + LIVE_W'(cnt_row_ff[0]);
            changed_in  = changed_ff + LIVE_W'(cnt_diff_ff[0]);
            cnt_row_in  = cnt_row_ff >> 1;
            cnt_diff_in = cnt_diff_ff >> 1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == COL_W'(CELLS - 1)) begin
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // advance the cursor, column first, then look up oldest-first slot
            if (col_ff == COL_W'(CELLS - 1)) begin
               col_in  = '0;
               srow_in = (srow_ff == ROW_W'(HISTORY_ROWS - 1)) ? '0 : srow_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            ring_sum = {1'b0, newest_ff} + {1'b0, srow_in} + 1'b1;
            if (ring_sum >= (ROW_W + 1)'(HISTORY_ROWS)) begin
               ring_sum = ring_sum - (ROW_W + 1)'(HISTORY_ROWS);
            end
            ring_idx = ring_sum[ROW_W-1:0];
            mem_re   = 1'b1;
            state_in = ST_OUT;
         end

         ST_OUT: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0,
                               COORD_FIELD_W'(srow_ff),
                               COORD_FIELD_W'(col_ff),
                               rd_valid_ff & rd_row_ff[col_ff],
                               COUNT_FIELD_W'(changed_ff),
                               COUNT_FIELD_W'(live_ff)};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
      mem_raddr = ring_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEED;
         init_ff      <= 1'b1;
         seen_ff      <= 1'b0;
         seed_use_ff  <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         col_ff       <= '0;
         srow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         seen_ff      <= seen_in;
         seed_use_ff  <= seed_use_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         col_ff       <= col_in;
         srow_ff      <= srow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rng_ff      <= rng_in;
      row_ff      <= row_in;
      cnt_row_ff  <= cnt_row_in;
      cnt_diff_ff <= cnt_diff_in;
      live_ff     <= live_in;
      changed_ff  <= changed_in;
      phase_ff    <= phase_in;
      newest_ff   <= newest_in;
      rsp_data_ff <= rsp_data_in;
   end

   // history ring memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_row_ff   <= ring_mem[mem_raddr];
         rd_valid_ff <= valid_ff[mem_raddr];
      end
   end

   // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
   // the live count never exceeds the row width outside the seed, lcg and count states
   assert property (@(posedge clock) disable iff (reset)
      (live_ff <= LIVE_W'(CELLS)) || (state_ff == ST_LCG) || (state_ff == ST_SEED)
         || (state_ff == ST_COUNT))
      else $error("live count above row width");

   // a reseed always leaves slot 0 of the history valid
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |=> valid_ff[0])
      else $error("slot 0 not valid after reseed");

   // an accepted request always starts work
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted request dropped");

   // a waiting response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending response overwritten");
`endif

endmodule
